FILE: rtl/core/assert_macros.svh
// assertion macros for the rtl of the playout target block
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk, off while rst_n is low
`define APT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// antecedent in this cycle implies consequent in the next one
`define APT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/apt_pkg.sv
// shared widths, types, register codes and reset values of the playout target block
// no dependencies; used by the channel interfaces and the top level
package apt_pkg;

    // smoothing and fixed point
    localparam int SMOOTH_SHIFT   = 4;
    localparam int DEVIATION_BITS = 32;
    localparam int JITTER_FRAC    = 4;
    localparam int JITTER_W       = DEVIATION_BITS + JITTER_FRAC;
    // desired = base + 4 * jitter_est / 2^JITTER_FRAC
    localparam int DESIRED_SHIFT  = JITTER_FRAC - 2;

    // field widths
    localparam int TIME_W    = 64;
    localparam int GAP_W     = TIME_W + 2;
    localparam int NS_W      = 30;
    localparam int JIT_OUT_W = 32;

    // configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef logic [TIME_W-1:0]         time_t;
    typedef logic [NS_W-1:0]           ns_t;
    typedef logic [JITTER_W-1:0]       jitter_t;
    typedef logic [DEVIATION_BITS-1:0] dev_t;
    typedef logic [JIT_OUT_W-1:0]      jit_out_t;

    // register index, byte address is 4 * index
    typedef enum logic [2:0] {
        REG_BASE,
        REG_FLOOR,
        REG_CEILING,
        REG_STEP_UP,
        REG_STEP_DOWN,
        REG_INIT_TARGET
    } cfg_reg_t;

    // reset values in nanoseconds
    localparam ns_t BASE_RST        = NS_W'(150000000);
    localparam ns_t FLOOR_RST       = NS_W'(120000000);
    localparam ns_t CEILING_RST     = NS_W'(350000000);
    localparam ns_t STEP_UP_RST     = NS_W'(10000000);
    localparam ns_t STEP_DOWN_RST   = NS_W'(250000);
    localparam ns_t INIT_TARGET_RST = NS_W'(150000000);

endpackage

FILE: rtl/core/apt_in_if.sv
// packet channel: arrival time and presentation timestamp of one packet per word
// depends on apt_pkg
interface apt_in_if;
    logic              valid;
    logic              ready;
    apt_pkg::time_t    arrival_ns;
    apt_pkg::time_t    pts_ns;

    modport source (output valid, output arrival_ns, output pts_ns, input ready);
    modport sink   (input valid, input arrival_ns, input pts_ns, output ready);
endinterface

FILE: rtl/core/apt_out_if.sv
// estimate channel: jitter, playout target and update flag, one word per packet
// depends on apt_pkg
interface apt_out_if;
    logic              valid;
    logic              ready;
    apt_pkg::jit_out_t jitter_ns;
    apt_pkg::ns_t      target_ns;
    logic              updated;

    modport source (output valid, output jitter_ns, output target_ns, output updated,
                    input ready);
    modport sink   (input valid, input jitter_ns, input target_ns, input updated,
                    output ready);
endinterface

FILE: rtl/core/adaptive_playout_target.sv
// top level of the adaptive playout target: jitter estimator and target tracker
// depends on apt_pkg, apt_in_if, apt_out_if and assert_macros.svh
//
// One packet word is taken per clock while the output side does not stall, and
// one estimate word comes out per packet. On acceptance the deviation between
// arrival gap and timestamp gap is formed and registered; when the output
// register is free, the jitter estimate, the clamped desired target and the
// stepped playout target are updated in one pass and loaded into the output
// register. A packet updates the estimate only when a nonzero previous
// timestamp is held and the new timestamp is larger. Writing initial_target_ns
// also loads the playout target at once.
`include "assert_macros.svh"

module adaptive_playout_target (
    input  logic                          clk,
    input  logic                          rst_n,
    apt_in_if.sink                        pkt,
    apt_out_if.source                     est,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [apt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [apt_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [apt_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready
);
    import apt_pkg::*;

    // configuration registers
    ns_t      base_reg;
    ns_t      floor_reg;
    ns_t      ceiling_reg;
    ns_t      step_up_reg;
    ns_t      step_down_reg;
    ns_t      init_target_reg;

    // estimator state
    time_t    last_pts_reg;
    time_t    last_arrival_reg;
    jitter_t  jitter_est_reg;
    ns_t      target_reg;
    jitter_t  jitter_est_next;
    ns_t      target_next;

    // deviation stage
    logic     dev_valid_reg;
    logic     dev_upd_reg;
    dev_t     dev_reg;

    // output register
    logic     res_valid_reg;
    jit_out_t res_jitter_reg;
    ns_t      res_target_reg;
    logic     res_updated_reg;

    // handshake
    logic     cfg_wr;
    cfg_reg_t cfg_sel;
    logic     pkt_acc;
    logic     res_free;
    logic     dev_move;

    // deviation path
    logic [GAP_W-1:0] gap_diff;
    logic [GAP_W-1:0] gap_mag;
    dev_t             dev_sat;
    logic             upd_in;

    // update path
    logic signed [JITTER_W:0] jit_diff;
    logic signed [JITTER_W:0] jit_step;
    logic signed [JITTER_W:0] jit_sum;
    jitter_t                  jitter_new;
    logic [JITTER_W:0]        desired_raw;
    logic [JITTER_W:0]        desired_fl;
    ns_t                      desired;
    logic [NS_W:0]            target_up;
    logic signed [NS_W+1:0]   target_down;
    ns_t                      target_moved;
    logic [TIME_W-1:0]        jit_int_wide;
    jit_out_t                 jit_int;

    // apb write decode and read mux
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

    always_comb
    begin
        case (cfg_sel)
            REG_BASE:        prdata = CFG_DATA_W'(base_reg);
            REG_FLOOR:       prdata = CFG_DATA_W'(floor_reg);
            REG_CEILING:     prdata = CFG_DATA_W'(ceiling_reg);
            REG_STEP_UP:     prdata = CFG_DATA_W'(step_up_reg);
            REG_STEP_DOWN:   prdata = CFG_DATA_W'(step_down_reg);
            REG_INIT_TARGET: prdata = CFG_DATA_W'(init_target_reg);
            default:         prdata = '0;
        endcase
    end

    // flow control: deviation stage moves when the output register frees up
    assign res_free  = !res_valid_reg || est.ready;
    assign dev_move  = dev_valid_reg && res_free;
    assign pkt.ready = !dev_valid_reg || res_free;
    assign pkt_acc   = pkt.valid && pkt.ready;

    // exact signed (arrival gap - timestamp gap), then magnitude and saturation
    always_comb
    begin
        upd_in   = (last_pts_reg != '0) && (pkt.pts_ns > last_pts_reg);
        gap_diff = {2'b00, pkt.arrival_ns} - {2'b00, last_arrival_reg}
                 - {2'b00, pkt.pts_ns} + {2'b00, last_pts_reg};
        gap_mag  = gap_diff[GAP_W-1] ? (~gap_diff + GAP_W'(1)) : gap_diff;
        if (|gap_mag[GAP_W-1:DEVIATION_BITS])
            dev_sat = '1;
        else
            dev_sat = gap_mag[DEVIATION_BITS-1:0];
    end

    // jitter update, desired target clamp and bounded target step
    always_comb
    begin
        jit_diff   = $signed({1'b0, dev_reg, {JITTER_FRAC{1'b0}}})
                   - $signed({1'b0, jitter_est_reg});
        // floor shift, also rounds negative steps away from zero
        jit_step   = jit_diff >>> SMOOTH_SHIFT;
        jit_sum    = $signed({1'b0, jitter_est_reg}) + jit_step;
        jitter_new = jit_sum[JITTER_W-1:0];

        desired_raw = (JITTER_W+1)'(base_reg) + (JITTER_W+1)'(jitter_new >> DESIRED_SHIFT);
        // floor first, ceiling last so the ceiling wins
        desired_fl  = (desired_raw < (JITTER_W+1)'(floor_reg))
                    ? (JITTER_W+1)'(floor_reg) : desired_raw;
        desired     = (desired_fl > (JITTER_W+1)'(ceiling_reg))
                    ? ceiling_reg : desired_fl[NS_W-1:0];

        target_up   = {1'b0, target_reg} + {1'b0, step_up_reg};
        target_down = $signed({2'b00, target_reg}) - $signed({2'b00, step_down_reg});
        if (desired > target_reg)
            target_moved = ({1'b0, desired} < target_up) ? desired : target_up[NS_W-1:0];
        else if (target_down[NS_W+1])
            target_moved = desired;
        else
            target_moved = (desired > target_down[NS_W-1:0])
                         ? desired : target_down[NS_W-1:0];

        jitter_est_next = dev_upd_reg ? jitter_new : jitter_est_reg;
        target_next     = dev_upd_reg ? target_moved : target_reg;

        // integer part, saturated to the output width
        jit_int_wide = TIME_W'(jitter_est_next >> JITTER_FRAC);
        if (|jit_int_wide[TIME_W-1:JIT_OUT_W])
            jit_int = '1;
        else
            jit_int = jit_int_wide[JIT_OUT_W-1:0];
    end

    // configuration registers and playout target
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg        <= BASE_RST;
            floor_reg       <= FLOOR_RST;
            ceiling_reg     <= CEILING_RST;
            step_up_reg     <= STEP_UP_RST;
            step_down_reg   <= STEP_DOWN_RST;
            init_target_reg <= INIT_TARGET_RST;
            target_reg      <= INIT_TARGET_RST;
        end
        else
        begin
            // a write of the initial target takes priority over the update
            if (dev_move && !(cfg_wr && cfg_sel == REG_INIT_TARGET))
                target_reg <= target_next;
            if (cfg_wr)
            begin
                case (cfg_sel)
                    REG_BASE:        base_reg      <= pwdata[NS_W-1:0];
                    REG_FLOOR:       floor_reg     <= pwdata[NS_W-1:0];
                    REG_CEILING:     ceiling_reg   <= pwdata[NS_W-1:0];
                    REG_STEP_UP:     step_up_reg   <= pwdata[NS_W-1:0];
                    REG_STEP_DOWN:   step_down_reg <= pwdata[NS_W-1:0];
                    REG_INIT_TARGET:
                    begin
                        init_target_reg <= pwdata[NS_W-1:0];
                        target_reg      <= pwdata[NS_W-1:0];
                    end
                    default:         ;
                endcase
            end
        end
    end

    // previous packet times, kept after every packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pts_reg     <= '0;
            last_arrival_reg <= '0;
        end
        else if (pkt_acc)
        begin
            last_pts_reg     <= pkt.pts_ns;
            last_arrival_reg <= pkt.arrival_ns;
        end
    end

    // jitter estimate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            jitter_est_reg <= '0;
        else if (dev_move)
            jitter_est_reg <= jitter_est_next;
    end

    // deviation stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dev_valid_reg <= 1'b0;
        else if (pkt.ready)
            dev_valid_reg <= pkt.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pkt_acc)
        begin
            dev_reg     <= dev_sat;
            dev_upd_reg <= upd_in;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_free)
            res_valid_reg <= dev_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (dev_move)
        begin
            res_jitter_reg  <= jit_int;
            res_target_reg  <= target_next;
            res_updated_reg <= dev_upd_reg;
        end
    end

    assign est.valid     = res_valid_reg;
    assign est.jitter_ns = res_jitter_reg;
    assign est.target_ns = res_target_reg;
    assign est.updated   = res_updated_reg;

    // checks
    `APT_ASSERT(a_stall_means_full, !pkt.ready |-> dev_valid_reg,
        "packet stalled with empty deviation stage")
    `APT_ASSERT_NEXT(a_move_gives_word, dev_move, est.valid,
        "deviation stage moved but no estimate word")
    `APT_ASSERT_NEXT(a_no_upd_keeps_jitter, dev_move && !dev_upd_reg,
        $stable(jitter_est_reg), "jitter changed without update")
    `APT_ASSERT_NEXT(a_no_upd_keeps_target, dev_move && !dev_upd_reg && !cfg_wr,
        $stable(target_reg), "target changed without update")

endmodule

FILE: bench/playout_estimate_checker.sv
// checker for the adaptive playout target: follows the packet, estimate and register ports
// keeps its own copy of the jitter and target state and compares every estimate word
// depends on apt_pkg, apt_in_if and apt_out_if
`timescale 1ns / 100ps

module playout_estimate_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    apt_in_if                              pkt,
    apt_out_if                             est,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [apt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [apt_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic                           pready,
    output int                             mismatches,
    output int                             pending
);
    import apt_pkg::*;

    localparam int REPORT_LIMIT = 10;
    localparam logic [TIME_W:0] DEV_MAX = (65'd1 << DEVIATION_BITS) - 65'd1;

    typedef struct packed {
        jit_out_t jitter_ns;
        ns_t      target_ns;
        logic     updated;
    } estimate_t;

    // register copies
    ns_t base_cfg;
    ns_t floor_cfg;
    ns_t ceiling_cfg;
    ns_t step_up_cfg;
    ns_t step_down_cfg;

    // estimator state
    time_t   prev_pts;
    time_t   prev_arrival;
    jitter_t jitter_fx;
    ns_t     target_now;

    estimate_t expected_estimates[$];

    // next estimate word for one packet, advancing the state
    function automatic estimate_t predict_estimate(input time_t arrival, input time_t pts);
        estimate_t       res;
        time_t           ts_gap;
        time_t           arr_gap;
        logic [TIME_W:0] dev_wide;
        dev_t            dev;
        longint          diff;
        longint          desired;
        longint          tgt;
        res.updated = (prev_pts != '0) && (pts > prev_pts);
        if (res.updated)
        begin
            // deviation between arrival gap and timestamp gap, backward arrival adds
            ts_gap = pts - prev_pts;
            if (arrival >= prev_arrival)
            begin
                arr_gap  = arrival - prev_arrival;
                dev_wide = (arr_gap >= ts_gap) ? {1'b0, arr_gap - ts_gap}
                                               : {1'b0, ts_gap - arr_gap};
            end
            else
                dev_wide = {1'b0, ts_gap} + {1'b0, prev_arrival - arrival};
            dev = (dev_wide > DEV_MAX) ? '1 : dev_wide[DEVIATION_BITS-1:0];

            // smoothing with floor division
            diff      = (longint'(dev) <<< JITTER_FRAC) - longint'(jitter_fx);
            jitter_fx = jitter_t'(longint'(jitter_fx) + (diff >>> SMOOTH_SHIFT));

            // desired target, floor first so the ceiling wins
            desired = longint'(base_cfg) + ((longint'(jitter_fx) * 4) >>> JITTER_FRAC);
            if (desired < longint'(floor_cfg))
                desired = longint'(floor_cfg);
            if (desired > longint'(ceiling_cfg))
                desired = longint'(ceiling_cfg);

            // bounded move toward desired, down step may go below zero
            tgt = longint'(target_now);
            if (desired > tgt)
                tgt = (desired < tgt + longint'(step_up_cfg)) ? desired
                                                              : tgt + longint'(step_up_cfg);
            else
                tgt = (desired > tgt - longint'(step_down_cfg)) ? desired
                                                                : tgt - longint'(step_down_cfg);
            target_now = ns_t'(tgt);
        end
        prev_arrival  = arrival;
        prev_pts      = pts;
        res.jitter_ns = jit_out_t'(jitter_fx >> JITTER_FRAC);
        res.target_ns = target_now;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        estimate_t want;
        if (!rst_n)
        begin
            base_cfg      = BASE_RST;
            floor_cfg     = FLOOR_RST;
            ceiling_cfg   = CEILING_RST;
            step_up_cfg   = STEP_UP_RST;
            step_down_cfg = STEP_DOWN_RST;
            prev_pts      = '0;
            prev_arrival  = '0;
            jitter_fx     = '0;
            target_now    = INIT_TARGET_RST;
            expected_estimates.delete();
            mismatches    = 0;
            pending      <= 0;
        end
        else
        begin
            // estimate word against the oldest prediction
            if (est.valid && est.ready)
            begin
                if (expected_estimates.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: estimate word with none expected: %s %0d %0d %0b",
                                 $realtime, "jitter/target/upd",
                                 est.jitter_ns, est.target_ns, est.updated);
                    mismatches++;
                end
                else
                begin
                    want = expected_estimates.pop_front();
                    if (est.jitter_ns !== want.jitter_ns || est.target_ns !== want.target_ns ||
                        est.updated !== want.updated)
                    begin
                        if (mismatches < REPORT_LIMIT)
                            $display({"%0t: estimate mismatch: exp jitter %0d target %0d ",
                                      "upd %0b, got jitter %0d target %0d upd %0b"},
                                     $realtime, want.jitter_ns, want.target_ns, want.updated,
                                     est.jitter_ns, est.target_ns, est.updated);
                        mismatches++;
                    end
                end
            end

            // packet word accepted
            if (pkt.valid && pkt.ready)
                expected_estimates.push_back(predict_estimate(pkt.arrival_ns, pkt.pts_ns));

            // register write, low 30 bits kept, unmapped index ignored
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_BASE:        base_cfg      = ns_t'(pwdata);
                    REG_FLOOR:       floor_cfg     = ns_t'(pwdata);
                    REG_CEILING:     ceiling_cfg   = ns_t'(pwdata);
                    REG_STEP_UP:     step_up_cfg   = ns_t'(pwdata);
                    REG_STEP_DOWN:   step_down_cfg = ns_t'(pwdata);
                    REG_INIT_TARGET: target_now    = ns_t'(pwdata);
                    default: ;
                endcase
            end

            pending <= expected_estimates.size();
        end
    end

endmodule

FILE: bench/tb_adaptive_playout_target.sv
// top of the playout target bench: clock, reset, packet stimulus, register writes, verdict
// depends on apt_pkg, apt_in_if, apt_out_if, adaptive_playout_target and the estimate checker
`timescale 1ns / 100ps

module tb_adaptive_playout_target;
    import apt_pkg::*;

    localparam int ITEMS_PER_PHASE = 255;
    localparam int PHASES          = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int SETTLE_CYCLES   = 4;
    localparam logic [2:0] SPARE_REG_LO = 3'd6;
    localparam logic [2:0] SPARE_REG_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int pending;

    // idle percentages, receiver hold request
    int   send_idle_pct = 16;
    int   recv_idle_pct = 48;
    logic hold_req      = 1'b0;

    // last packet offered, base of the next timestamp chain
    time_t sent_arrival = '0;
    time_t sent_pts     = '0;

    apt_in_if  pkt_ch ();
    apt_out_if est_ch ();

    adaptive_playout_target u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pkt     (pkt_ch),
        .est     (est_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    playout_estimate_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt        (pkt_ch),
        .est        (est_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one packet word, random idle cycles ahead of it
    task automatic send_packet(input time_t arrival, input time_t pts);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pkt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pkt_ch.valid      <= 1'b1;
        pkt_ch.arrival_ns <= arrival;
        pkt_ch.pts_ns     <= pts;
        sent_arrival = arrival;
        sent_pts     = pts;
        do
            @(posedge clk);
        while (!pkt_ch.ready);
    endtask

    // stop offering and wait until every estimate word is back
    task automatic drain_estimates();
        pkt_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // setup and access phases, then the bus returns to idle
    task automatic write_register(input logic [2:0] index, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // write all registers for one phase
    task automatic load_setting(input int phase);
        logic [CFG_DATA_W-1:0] vals [REG_INIT_TARGET+1];
        cfg_reg_t              r;
        r = r.first();
        repeat (r.num())
        begin
            case (phase)
                0:
                begin
                    vals[REG_BASE]        = CFG_DATA_W'(BASE_RST);
                    vals[REG_FLOOR]       = CFG_DATA_W'(FLOOR_RST);
                    vals[REG_CEILING]     = CFG_DATA_W'(CEILING_RST);
                    vals[REG_STEP_UP]     = CFG_DATA_W'(STEP_UP_RST);
                    vals[REG_STEP_DOWN]   = CFG_DATA_W'(STEP_DOWN_RST);
                    vals[REG_INIT_TARGET] = CFG_DATA_W'(INIT_TARGET_RST);
                end
                // target follows desired with no bound on its moves
                1:
                begin
                    vals[REG_BASE]        = 0;
                    vals[REG_FLOOR]       = 0;
                    vals[REG_CEILING]     = 1_000_000_000;
                    vals[REG_STEP_UP]     = 1_000_000_000;
                    vals[REG_STEP_DOWN]   = 1_000_000_000;
                    vals[REG_INIT_TARGET] = 0;
                end
                // floor above ceiling, crawling target from the top
                2:
                begin
                    vals[REG_BASE]        = 1_000_000_000;
                    vals[REG_FLOOR]       = 1_000_000_000;
                    vals[REG_CEILING]     = 0;
                    vals[REG_STEP_UP]     = 0;
                    vals[REG_STEP_DOWN]   = 1;
                    vals[REG_INIT_TARGET] = 1_000_000_000;
                end
                3:
                begin
                    vals[REG_BASE]        = $urandom_range(0, 300_000_000);
                    vals[REG_FLOOR]       = $urandom_range(0, 300_000_000);
                    vals[REG_CEILING]     = $urandom_range(0, 1_000_000_000);
                    vals[REG_STEP_UP]     = $urandom_range(0, 20_000_000);
                    vals[REG_STEP_DOWN]   = $urandom_range(0, 20_000_000);
                    vals[REG_INIT_TARGET] = $urandom_range(0, 1_000_000_000);
                end
                // upper bits set, only the low 30 count
                4:
                begin
                    vals[REG_BASE]        = {2'b11, 30'($urandom_range(0, 300_000_000))};
                    vals[REG_FLOOR]       = {2'b10, 30'($urandom_range(0, 300_000_000))};
                    vals[REG_CEILING]     = {2'b01, 30'($urandom)};
                    vals[REG_STEP_UP]     = {2'b11, 30'($urandom_range(0, 20_000_000))};
                    vals[REG_STEP_DOWN]   = {2'b11, 30'($urandom_range(0, 20_000_000))};
                    vals[REG_INIT_TARGET] = $urandom;
                end
                default:
                begin
                    vals[REG_BASE]        = $urandom_range(0, 1_000_000_000);
                    vals[REG_FLOOR]       = $urandom_range(0, 1_000_000_000);
                    vals[REG_CEILING]     = $urandom_range(0, 1_000_000_000);
                    vals[REG_STEP_UP]     = $urandom_range(0, 1_000_000_000);
                    vals[REG_STEP_DOWN]   = $urandom_range(0, 1_000_000_000);
                    vals[REG_INIT_TARGET] = $urandom_range(0, 1_000_000_000);
                end
            endcase
            write_register(r, vals[r]);
            r = r.next();
        end
        if (phase == 4)
        begin
            write_register(SPARE_REG_LO, $urandom);
            write_register(SPARE_REG_HI, $urandom);
        end
    endtask

    // mostly steady timestamp chains with jittered arrivals, some noise
    task automatic random_packet();
        int unsigned pick;
        int unsigned spread;
        time_t       gap;
        time_t       arrival;
        time_t       pts;
        longint      offset;
        pick = $urandom_range(99);
        gap  = time_t'($urandom_range(1, 40_000_000));
        case ($urandom_range(3))
            0:       spread = 0;
            1:       spread = 2_000;
            2:       spread = 2_000_000;
            default: spread = 100_000_000;
        endcase
        offset  = longint'($urandom_range(0, 2 * spread)) - longint'(spread);
        arrival = sent_arrival + gap + time_t'(offset);
        pts     = sent_pts + gap;
        if (pick < 80)
            ;
        else if (pick < 85)
            pts = '0;
        else if (pick < 90)
        begin
            arrival = {$urandom, $urandom};
            pts     = {$urandom, $urandom};
        end
        else if (pick < 93)
            pts = sent_pts;
        else if (pick < 96)
            pts = sent_pts - time_t'($urandom_range(1, 1_000_000));
        else
            arrival = sent_arrival - {$urandom, $urandom};
        send_packet(arrival, pts);
    endtask

    // receiver: random ready, or one long hold on request
    initial
    begin
        est_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                est_ch.ready <= 1'b0;
                hold_req     <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                est_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no word moving
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        wait (rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((pkt_ch.valid && pkt_ch.ready) || (est_ch.valid && est_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb_adaptive_playout_target: FAIL");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        rst_n             <= 1'b0;
        pkt_ch.valid      <= 1'b0;
        pkt_ch.arrival_ns <= '0;
        pkt_ch.pts_ns     <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no timestamp, then a zero previous timestamp
        send_packet(64'd1_000, 64'd0);
        send_packet(64'd2_000, 64'd5_000);
        // first real update
        send_packet(64'd40_002_000, 64'd20_005_000);
        // equal and older timestamps
        send_packet(64'd50_000_000, 64'd20_005_000);
        send_packet(64'd60_000_000, 64'd10_000_000);
        // arrival going backward
        send_packet(64'd55_000_000, 64'd30_000_000);
        // deviation beyond 32 bits
        send_packet(64'h4000_0000_0000_0000, 64'd30_000_001);
        send_packet('1, 64'h8000_0000_0000_0000);
        // backward arrival whose sum overflows 64 bits
        send_packet('0, '1);
        send_packet('1, '0);
        send_packet(64'd1, 64'd1);
        // zero deviation, estimate decays
        for (int k = 2; k < 8; k++)
            send_packet(time_t'(k * 1000), time_t'(k * 1000));

        // floor above ceiling, down step below zero, wide values, unmapped index
        drain_estimates();
        write_register(REG_FLOOR, 32'd300_000_000);
        write_register(REG_CEILING, 32'd200_000_000);
        write_register(REG_STEP_DOWN, 32'd1_000_000_000);
        write_register(REG_INIT_TARGET, 32'hC000_0000 | 32'd500_000_000);
        write_register(SPARE_REG_LO, 32'hFFFF_FFFF);
        write_register(SPARE_REG_HI, 32'h0000_0001);
        send_packet(64'd20_008_000, 64'd10_008_000);
        send_packet(64'd40_000_000, 64'd20_000_000);
        send_packet(64'd39_000_000, 64'd30_000_000);
        send_packet(64'd90_000_000, 64'd40_000_000);

        // random phases: sender light and receiver heavy idling, swapped, then none
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_estimates();
            send_idle_pct = (phase < 2) ? 16 : (phase < 4) ? 48 : 0;
            recv_idle_pct = (phase < 2) ? 48 : (phase < 4) ? 16 : 0;
            load_setting(phase);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == 100 && (phase == 1 || phase == 5))
                    hold_req <= 1'b1;
                if (n == 150 && phase == 3)
                    drain_estimates();
                random_packet();
            end
        end

        drain_estimates();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb_adaptive_playout_target: PASS");
        else
            $display("tb_adaptive_playout_target: FAIL");
        $finish;
    end

endmodule
